>>> rtl/core/gbfp_pkg.sv
// ----------------------------------------------------------------------------
// gbfp_pkg: binary GNSS frame parser types and constants
// Frame phases, status codes, the result beat layout and protocol constants.
// ----------------------------------------------------------------------------
package gbfp_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_SYNC   = 3'd1,
    PH_HEADER = 3'd2,
    PH_COPY   = 3'd3,
    PH_SUM1   = 3'd4,
    PH_SUM2   = 3'd5
  } phase_t;

  // Status reported with each result beat
  typedef enum logic [1:0] {
    ST_UNKNOWN = 2'd0,
    ST_CONT    = 2'd1,
    ST_DONE    = 2'd2
  } status_t;

  // One result beat
  typedef struct packed {
    status_t     status;
    logic        data_valid;
    logic [7:0]  data_index;
    logic [7:0]  data_byte;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic [7:0]  fix_sv_count;
    logic        sv_valid;
    logic [31:0] quant_error_ps;
    logic        quant_valid;
  } result_t;

  // Sync pair
  localparam logic [7:0] SYNC_1 = 8'hB5;
  localparam logic [7:0] SYNC_2 = 8'h62;

  // Message identifiers
  localparam logic [7:0] CLS_NAV    = 8'h01;
  localparam logic [7:0] ID_NAV_SOL = 8'h06;
  localparam logic [7:0] CLS_TIM    = 8'h0D;
  localparam logic [7:0] ID_TIM_TP  = 8'h01;

  // Store layout: class, id, two length bytes, then payload
  localparam logic [7:0]  HDR_BYTES      = 8'd4;
  localparam logic [7:0]  SV_IDX         = 8'd51;  // payload byte 47
  localparam logic [7:0]  SV_MIN_TOTAL   = 8'd56;  // 52 payload bytes
  localparam logic [7:0]  QERR_FIRST_IDX = 8'd12;  // payload bytes 8..11
  localparam logic [7:0]  QERR_LAST_IDX  = 8'd15;
  localparam logic [7:0]  QERR_MIN_TOTAL = 8'd20;  // 16 payload bytes
  localparam logic [15:0] TOTAL_SAT      = 16'hFFFF;

endpackage

>>> rtl/core/gnss_binary_frame_parser_core.sv
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_core: sync 0xB5 0x62 frame parser, Fletcher-8 checked
// Takes one serial byte per beat and returns one result beat per byte.
// ----------------------------------------------------------------------------
// Each accepted byte produces exactly one result beat. When a byte is taken,
// the phase machine, Fletcher-8 sums and frame fields update in the same
// cycle and the result lands in an output register, so a new byte can be taken
// every clock. A second skid register holds one more result, so input keeps
// flowing for one beat while out_ready is low; in_ready drops only when both
// result registers are full. With the output side ready, each result beat is
// out in the cycle after its byte. Header and payload bytes are echoed with
// their store index (0 class, 1 id, 2..3 length, 4 and up payload); a frame
// longer than FRAME_STORE_BYTES stored bytes is dropped with status unknown.
// Status complete comes with class, id and length, plus the satellite count for
// NAV-SOL or the quantization error for TIM-TP when the payload is long enough.
module gnss_binary_frame_parser_core #(
  parameter int FRAME_STORE_BYTES = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_data_valid,
  output logic [7:0]         out_data_index,
  output logic [7:0]         out_data_byte,
  output logic [7:0]         out_msg_class,
  output logic [7:0]         out_msg_id,
  output logic [15:0]        out_payload_len,
  output logic [7:0]         out_fix_sv_count,
  output logic               out_sv_valid,
  output logic signed [31:0] out_quant_error_ps,
  output logic               out_quant_valid
);
  import gbfp_pkg::*;

  localparam logic [7:0] StoreMax = 8'(FRAME_STORE_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] total_r, total_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [31:0] cil_r, cil_nxt;
  logic [7:0]  sv_r, sv_nxt;
  logic [31:0] qerr_r, qerr_nxt;

  result_t     res;
  result_t     out_r, skid_r;
  logic        out_vld_r, skid_vld_r;
  logic        acc, out_fire;

  // Store helpers
  logic        store;
  logic [7:0]  st_count, st_sum_a, st_sum_b;
  logic [31:0] st_cil, st_qerr;
  logic [7:0]  st_sv;
  logic [16:0] len_plus;
  logic [15:0] new_total;

  assign in_ready = !skid_vld_r;
  assign acc      = in_valid && in_ready;
  assign out_fire = out_vld_r && out_ready;

  // Effect of storing the current byte at index count_r
  always_comb begin
    st_count = count_r + 8'd1;
    st_sum_a = sum_a_r + in_rx_byte;
    st_sum_b = sum_b_r + st_sum_a;
    st_cil   = cil_r;
    st_sv    = sv_r;
    st_qerr  = qerr_r;
    if (count_r < HDR_BYTES) begin
      st_cil[{count_r[1:0], 3'b000} +: 8] = in_rx_byte;
    end
    if (count_r == SV_IDX) begin
      st_sv = in_rx_byte;
    end
    if (count_r >= QERR_FIRST_IDX && count_r <= QERR_LAST_IDX) begin
      st_qerr[{count_r[1:0], 3'b000} +: 8] = in_rx_byte;
    end
    len_plus  = {1'b0, st_cil[31:16]} + 17'd4;
    new_total = len_plus[16] ? TOTAL_SAT : len_plus[15:0];
  end

  // Next state and result for the incoming byte
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    total_nxt = total_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    cil_nxt   = cil_r;
    sv_nxt    = sv_r;
    qerr_nxt  = qerr_r;
    store     = 1'b0;
    res       = '0;
    res.status = ST_UNKNOWN;
    unique case (phase_r)
      PH_WAIT: begin
        if (in_rx_byte == SYNC_1) begin
          phase_nxt  = PH_SYNC;
          res.status = ST_CONT;
        end
      end
      PH_SYNC: begin
        if (in_rx_byte == SYNC_2) begin
          count_nxt  = '0;
          sum_a_nxt  = '0;
          sum_b_nxt  = '0;
          phase_nxt  = PH_HEADER;
          res.status = ST_CONT;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end
      PH_HEADER: begin
        store      = 1'b1;
        res.status = ST_CONT;
        if (st_count >= HDR_BYTES) begin
          total_nxt = new_total;
          phase_nxt = ({8'd0, st_count} >= new_total) ? PH_SUM1 : PH_COPY;
        end
      end
      PH_COPY: begin
        if (count_r >= StoreMax) begin
          // Drop the frame on store overflow
          phase_nxt = PH_WAIT;
        end else begin
          store      = 1'b1;
          res.status = ST_CONT;
          if ({8'd0, st_count} >= total_r) begin
            phase_nxt = PH_SUM1;
          end
        end
      end
      PH_SUM1: begin
        if (in_rx_byte == sum_a_r) begin
          phase_nxt  = PH_SUM2;
          res.status = ST_CONT;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end
      PH_SUM2: begin
        phase_nxt = PH_WAIT;
        if (in_rx_byte == sum_b_r) begin
          res.status      = ST_DONE;
          res.msg_class   = cil_r[7:0];
          res.msg_id      = cil_r[15:8];
          res.payload_len = cil_r[31:16];
          if (cil_r[7:0] == CLS_NAV && cil_r[15:8] == ID_NAV_SOL &&
              count_r >= SV_MIN_TOTAL) begin
            res.fix_sv_count = sv_r;
            res.sv_valid     = 1'b1;
          end else if (cil_r[7:0] == CLS_TIM && cil_r[15:8] == ID_TIM_TP &&
                       count_r >= QERR_MIN_TOTAL) begin
            res.quant_error_ps = qerr_r;
            res.quant_valid    = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase
    if (store) begin
      count_nxt      = st_count;
      sum_a_nxt      = st_sum_a;
      sum_b_nxt      = st_sum_b;
      cil_nxt        = st_cil;
      sv_nxt         = st_sv;
      qerr_nxt       = st_qerr;
      res.data_valid = 1'b1;
      res.data_index = count_r;
      res.data_byte  = in_rx_byte;
    end
  end

  // Parser state, advanced on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      count_r <= '0;
      total_r <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      cil_r   <= '0;
      sv_r    <= '0;
      qerr_r  <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      cil_r   <= cil_nxt;
      sv_r    <= sv_nxt;
      qerr_r  <= qerr_nxt;
    end
  end

  // Output register plus skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_fire) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= acc;
      end
    end else if (acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    if (!out_vld_r || out_fire) begin
      if (skid_vld_r) begin
        out_r <= skid_r;
      end else if (acc) begin
        out_r <= res;
      end
    end else if (acc) begin
      skid_r <= res;
    end
  end

  // Drive result ports
  assign out_valid          = out_vld_r;
  assign out_status         = out_r.status;
  assign out_data_valid     = out_r.data_valid;
  assign out_data_index     = out_r.data_index;
  assign out_data_byte      = out_r.data_byte;
  assign out_msg_class      = out_r.msg_class;
  assign out_msg_id         = out_r.msg_id;
  assign out_payload_len    = out_r.payload_len;
  assign out_fix_sv_count   = out_r.fix_sv_count;
  assign out_sv_valid       = out_r.sv_valid;
  assign out_quant_error_ps = signed'(out_r.quant_error_ps);
  assign out_quant_valid    = out_r.quant_valid;

  // A full skid stage implies a full output register
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full while output register empty");

  // A stored byte only comes with a continuing frame
  a_store_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.data_valid) |-> (out_r.status == ST_CONT))
    else $error("stored byte reported without continuing status");

  // Extracted fields are exclusive and only on complete frames
  a_extract_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_r.sv_valid || out_r.quant_valid)) |->
      (out_r.status == ST_DONE && !(out_r.sv_valid && out_r.quant_valid)))
    else $error("extracted field on a frame that is not complete");

  // Payload copy only runs after the full header is stored
  a_copy_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COPY) |-> (count_r >= HDR_BYTES && total_r > {8'd0, count_r}))
    else $error("payload phase entered with a short header");

  // Store never goes past its capacity
  a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && store) |-> (count_r < StoreMax || phase_r == PH_HEADER))
    else $error("byte stored beyond frame store capacity");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: binary GNSS frame parser core
// Feeds serial bytes through the valid/ready input, predicts every result beat
// with an in-bench parser model and compares the beats field by field. A short
// table of directed bytes comes first, then random frames, noise and broken
// frames, with random gaps and back-pressure on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import gbfp_pkg::*;

  localparam int STORE_BYTES    = 128;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_CYCLES     = 10;

  // Ways a generated frame can be broken
  typedef enum int {
    FAULT_NONE,
    FAULT_SUM_A,
    FAULT_SUM_B,
    FAULT_CUT
  } frame_fault_t;

  // One row of the directed byte table
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    result_t    want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_rx_byte;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic              out_data_valid;
  logic [7:0]        out_data_index;
  logic [7:0]        out_data_byte;
  logic [7:0]        out_msg_class;
  logic [7:0]        out_msg_id;
  logic [15:0]       out_payload_len;
  logic [7:0]        out_fix_sv_count;
  logic              out_sv_valid;
  logic signed [31:0] out_quant_error_ps;
  logic              out_quant_valid;

  // Expected result beat that rides with the current input beat, if typed in
  bit                cur_typed;
  result_t           cur_want;

  // Parser model state
  phase_t            p_phase;
  logic [7:0]        p_count;
  logic [15:0]       p_total;
  logic [7:0]        p_sum_a;
  logic [7:0]        p_sum_b;
  logic [31:0]       p_hdr;
  logic [7:0]        p_sv;
  logic [31:0]       p_qerr;

  result_t           pending_results[$];
  result_t           pred_r;
  result_t           want_r;
  result_t           got_r;
  dir_row_t          dir_rows[$];

  int                mismatch_cnt;
  int                beat_cnt;
  int                idle_cycles;
  int                frame_items;
  int                stall_left;
  int                stall_gap;
  bit                in_burst;
  bit                out_calm;

  gnss_binary_frame_parser_core #(
    .FRAME_STORE_BYTES(STORE_BYTES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_data_valid    (out_data_valid),
    .out_data_index    (out_data_index),
    .out_data_byte     (out_data_byte),
    .out_msg_class     (out_msg_class),
    .out_msg_id        (out_msg_id),
    .out_payload_len   (out_payload_len),
    .out_fix_sv_count  (out_fix_sv_count),
    .out_sv_valid      (out_sv_valid),
    .out_quant_error_ps(out_quant_error_ps),
    .out_quant_valid   (out_quant_valid)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Build a result beat with the satellite and quantization fields cleared
  function automatic result_t res(status_t st, logic dv, logic [7:0] idx, logic [7:0] db,
                                  logic [7:0] cls, logic [7:0] id, logic [15:0] len);
    result_t r;
    r = '0;
    r.status      = st;
    r.data_valid  = dv;
    r.data_index  = idx;
    r.data_byte   = db;
    r.msg_class   = cls;
    r.msg_id      = id;
    r.payload_len = len;
    return r;
  endfunction

  // Random byte, biased toward the sync values
  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return SYNC_1;
    if (r < 15) return SYNC_2;
    return 8'($urandom_range(0, 255));
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Store one header or payload byte into the model frame
  task automatic store_frame_byte(input logic [7:0] rx, inout result_t r);
    logic [7:0] idx;
    idx = p_count;
    r.data_valid = 1'b1;
    r.data_index = idx;
    r.data_byte  = rx;
    if (idx < HDR_BYTES) p_hdr[8*idx +: 8] = rx;
    if (idx == SV_IDX) p_sv = rx;
    if (idx >= QERR_FIRST_IDX && idx <= QERR_LAST_IDX) p_qerr[8*(idx - QERR_FIRST_IDX) +: 8] = rx;
    p_count = idx + 8'd1;
    p_sum_a = p_sum_a + rx;
    p_sum_b = p_sum_b + p_sum_a;
  endtask

  // Advance the parser model by one byte and return the beat it produces
  task automatic parse_rx_byte(input logic [7:0] rx, output result_t r);
    logic [16:0] total;
    r = '0;
    r.status = ST_UNKNOWN;
    case (p_phase)
      PH_WAIT: begin
        if (rx == SYNC_1) begin
          p_phase  = PH_SYNC;
          r.status = ST_CONT;
        end
      end
      PH_SYNC: begin
        if (rx == SYNC_2) begin
          p_count  = '0;
          p_sum_a  = '0;
          p_sum_b  = '0;
          p_phase  = PH_HEADER;
          r.status = ST_CONT;
        end else begin
          p_phase = PH_WAIT;
        end
      end
      PH_HEADER: begin
        store_frame_byte(rx, r);
        if (p_count >= HDR_BYTES) begin
          total   = {1'b0, p_hdr[31:16]} + 17'd4;
          p_total = total[16] ? TOTAL_SAT : total[15:0];
          p_phase = ({8'd0, p_count} >= p_total) ? PH_SUM1 : PH_COPY;
        end
        r.status = ST_CONT;
      end
      PH_COPY: begin
        if (int'(p_count) >= STORE_BYTES) begin
          // drop the frame on store overflow
          p_phase = PH_WAIT;
        end else begin
          store_frame_byte(rx, r);
          if ({8'd0, p_count} >= p_total) p_phase = PH_SUM1;
          r.status = ST_CONT;
        end
      end
      PH_SUM1: begin
        if (rx == p_sum_a) begin
          p_phase  = PH_SUM2;
          r.status = ST_CONT;
        end else begin
          p_phase = PH_WAIT;
        end
      end
      PH_SUM2: begin
        p_phase = PH_WAIT;
        if (rx == p_sum_b) begin
          r.status      = ST_DONE;
          r.msg_class   = p_hdr[7:0];
          r.msg_id      = p_hdr[15:8];
          r.payload_len = p_hdr[31:16];
          if (p_hdr[7:0] == CLS_NAV && p_hdr[15:8] == ID_NAV_SOL && p_count >= SV_MIN_TOTAL) begin
            r.fix_sv_count = p_sv;
            r.sv_valid     = 1'b1;
          end else if (p_hdr[7:0] == CLS_TIM && p_hdr[15:8] == ID_TIM_TP &&
                       p_count >= QERR_MIN_TOTAL) begin
            r.quant_error_ps = p_qerr;
            r.quant_valid    = 1'b1;
          end
        end
      end
      default: p_phase = PH_WAIT;
    endcase
  endtask

  // Compare one field of a result beat
  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      if (mismatch_cnt < 10)
        $display("mismatch beat %0d %s: expected %0h, got %0h", beat_cnt, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Predict on input beats, check output beats, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      idle_cycles++;
      if (in_valid && in_ready) begin
        parse_rx_byte(in_rx_byte, pred_r);
        pending_results.push_back(cur_typed ? cur_want : pred_r);
        idle_cycles = 0;
      end
      if (out_valid && out_ready) begin
        got_r.status         = status_t'(out_status);
        got_r.data_valid     = out_data_valid;
        got_r.data_index     = out_data_index;
        got_r.data_byte      = out_data_byte;
        got_r.msg_class      = out_msg_class;
        got_r.msg_id         = out_msg_id;
        got_r.payload_len    = out_payload_len;
        got_r.fix_sv_count   = out_fix_sv_count;
        got_r.sv_valid       = out_sv_valid;
        got_r.quant_error_ps = out_quant_error_ps;
        got_r.quant_valid    = out_quant_valid;
        if (pending_results.size() == 0) begin
          if (mismatch_cnt < 10) $display("unexpected result beat %0d", beat_cnt);
          mismatch_cnt++;
        end else begin
          want_r = pending_results.pop_front();
          cmp_field("status", 32'(want_r.status), 32'(got_r.status));
          cmp_field("data_valid", 32'(want_r.data_valid), 32'(got_r.data_valid));
          cmp_field("data_index", 32'(want_r.data_index), 32'(got_r.data_index));
          cmp_field("data_byte", 32'(want_r.data_byte), 32'(got_r.data_byte));
          cmp_field("msg_class", 32'(want_r.msg_class), 32'(got_r.msg_class));
          cmp_field("msg_id", 32'(want_r.msg_id), 32'(got_r.msg_id));
          cmp_field("payload_len", 32'(want_r.payload_len), 32'(got_r.payload_len));
          cmp_field("fix_sv_count", 32'(want_r.fix_sv_count), 32'(got_r.fix_sv_count));
          cmp_field("sv_valid", 32'(want_r.sv_valid), 32'(got_r.sv_valid));
          cmp_field("quant_error_ps", want_r.quant_error_ps, got_r.quant_error_ps);
          cmp_field("quant_valid", 32'(want_r.quant_valid), 32'(got_r.quant_valid));
        end
        beat_cnt++;
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat for %0d cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Result side back-pressure: random stalls, with calm stretches
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (out_calm) begin
      out_ready <= 1'b1;
    end else begin
      stall_gap = gap_len();
      out_ready <= (stall_gap == 0);
      stall_left = (stall_gap > 0) ? stall_gap - 1 : 0;
    end
  end

  // Send one byte: optional idle gap, then hold valid until accepted
  task automatic send_byte(input logic [7:0] rx, input bit typed, input result_t want);
    int g;
    g = in_burst ? 0 : gap_len();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    cur_typed  <= typed;
    cur_want   <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_plain(input logic [7:0] rx);
    send_byte(rx, 1'b0, '0);
  endtask

  // Hold the input side until every expected beat has come back
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Send a framed message with correct or broken sums, or cut short; overflow when too long
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input logic [15:0] len,
                            input frame_fault_t fault);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] pb;
    logic [7:0] hdr [4];
    int         n;
    int         cut;
    bit         overflow;
    a = '0;
    b = '0;
    hdr[0] = cls;
    hdr[1] = id;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    overflow = (int'(len) > STORE_BYTES - 4);
    n = overflow ? STORE_BYTES - 4 + 1 : int'(len);
    cut = (fault == FAULT_CUT) ? $urandom_range(0, n) : n + 1;
    send_plain(SYNC_1);
    send_plain(SYNC_2);
    for (int i = 0; i < 4; i++) begin
      send_plain(hdr[i]);
      a = a + hdr[i];
      b = b + a;
    end
    frame_items += 6;
    for (int i = 0; i < n; i++) begin
      if (i == cut) return;
      pb = rand_byte();
      send_plain(pb);
      a = a + pb;
      b = b + a;
      frame_items++;
    end
    if (overflow || fault == FAULT_CUT) return;
    // corrupt one sum by a nonzero flip
    if (fault == FAULT_SUM_A) a = a ^ 8'($urandom_range(1, 255));
    if (fault == FAULT_SUM_B) b = b ^ 8'($urandom_range(1, 255));
    send_plain(a);
    send_plain(b);
    frame_items += 2;
  endtask

  // Stimulus
  initial begin
    int          pick;
    logic [15:0] len;
    logic [7:0]  bad;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = '0;
    cur_typed    = 1'b0;
    cur_want     = '0;
    p_phase      = PH_WAIT;
    p_count      = '0;
    p_total      = '0;
    p_sum_a      = '0;
    p_sum_b      = '0;
    p_hdr        = '0;
    p_sv         = '0;
    p_qerr       = '0;
    mismatch_cnt = 0;
    beat_cnt     = 0;
    idle_cycles  = 0;
    frame_items  = 0;
    stall_left   = 0;
    stall_gap    = 0;
    in_burst     = 1'b0;
    out_calm     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Extremes while hunting, a bad second sync byte
    dir_rows.push_back('{8'h00, 1'b1, res(ST_UNKNOWN, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{8'hFF, 1'b1, res(ST_UNKNOWN, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{SYNC_1, 1'b1, res(ST_CONT, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{SYNC_1, 1'b1, res(ST_UNKNOWN, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{SYNC_2, 1'b1, res(ST_UNKNOWN, 0, 0, 0, 0, 0, 0)});
    // Empty-payload frame, class 5 id 1, good sums
    dir_rows.push_back('{SYNC_1, 1'b1, res(ST_CONT, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{SYNC_2, 1'b1, res(ST_CONT, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{8'h05, 1'b1, res(ST_CONT, 1, 0, 8'h05, 0, 0, 0)});
    dir_rows.push_back('{8'h01, 1'b1, res(ST_CONT, 1, 1, 8'h01, 0, 0, 0)});
    dir_rows.push_back('{8'h00, 1'b1, res(ST_CONT, 1, 2, 8'h00, 0, 0, 0)});
    dir_rows.push_back('{8'h00, 1'b1, res(ST_CONT, 1, 3, 8'h00, 0, 0, 0)});
    dir_rows.push_back('{8'h06, 1'b1, res(ST_CONT, 0, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{8'h17, 1'b1, res(ST_DONE, 0, 0, 0, 8'h05, 8'h01, 0)});
    // All-zero header, then a wrong first sum
    dir_rows.push_back('{SYNC_1, 1'b0, '0});
    dir_rows.push_back('{SYNC_2, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{8'h01, 1'b1, res(ST_UNKNOWN, 0, 0, 0, 0, 0, 0)});
    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);
    hold_until_drained();

    // Random frames, broken frames and noise
    while (frame_items < RANDOM_ITEMS) begin
      in_burst = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        len = ($urandom_range(0, 2) == 0) ? 16'd52 : 16'($urandom_range(40, 124));
        send_frame(CLS_NAV, ID_NAV_SOL, len, FAULT_NONE);
      end else if (pick < 45) begin
        len = ($urandom_range(0, 2) == 0) ? 16'd16 : 16'($urandom_range(8, 28));
        send_frame(CLS_TIM, ID_TIM_TP, len, FAULT_NONE);
      end else if (pick < 65) begin
        len = ($urandom_range(0, 19) == 0) ? 16'(STORE_BYTES - 4) : 16'($urandom_range(0, 12));
        send_frame(rand_byte(), rand_byte(), len, FAULT_NONE);
      end else if (pick < 73) begin
        send_frame(rand_byte(), rand_byte(), 16'($urandom_range(0, 20)),
                   ($urandom_range(0, 1) == 0) ? FAULT_SUM_A : FAULT_SUM_B);
      end else if (pick < 77) begin
        // truncated frame, then noise lands in the middle of it
        send_frame(rand_byte(), rand_byte(), 16'($urandom_range(1, 30)), FAULT_CUT);
        repeat ($urandom_range(1, 6)) send_plain(rand_byte());
      end else if (pick < 80) begin
        case ($urandom_range(0, 3))
          0:       len = 16'hFFFF;
          1:       len = 16'(STORE_BYTES - 3);
          default: len = 16'($urandom_range(STORE_BYTES - 2, 65535));
        endcase
        send_frame(rand_byte(), rand_byte(), len, FAULT_NONE);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 6)) send_plain(rand_byte());
      end else begin
        do bad = rand_byte(); while (bad == SYNC_2);
        send_plain(SYNC_1);
        send_plain(bad);
      end
      if ($urandom_range(0, 11) == 0) hold_until_drained();
    end

    // Drain and let the pipeline settle
    hold_until_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
